FILE: hdl/rpwf_pkg.sv
// ---------------------------------------------------------------------------
// rpwf_pkg: shared types and constants for the RC pulse width mapper
// Register indexes, reset values, input codes and the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package rpwf_pkg;

  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CNT_W     = 8;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PULSE_MIN     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_MAX     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COORD_MIN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COORD_MAX     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STOPPED_WIDTH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OVF_LIMIT     = 3'd5;

  // reset values
  localparam logic [DATA_W-1:0] PULSE_MIN_RST     = 16'd1000;
  localparam logic [DATA_W-1:0] PULSE_MAX_RST     = 16'd2000;
  localparam logic [DATA_W-1:0] COORD_MIN_RST     = 16'hFF9C;  // -100
  localparam logic [DATA_W-1:0] COORD_MAX_RST     = 16'd100;
  localparam logic [DATA_W-1:0] STOPPED_WIDTH_RST = 16'd1500;
  localparam logic [CNT_W-1:0]  OVF_LIMIT_RST     = 8'd3;

  // input codes
  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_TICK  = 1'b1;
  localparam logic LEVEL_HIGH = 1'b1;

  // divider: quotient magnitude always fits 16 bits
  localparam int unsigned DIV_STEPS = 16;

  typedef struct packed {
    logic apply;     // update channel state from the accepted beat
    logic setup;     // clamp and form the spans for the selected channel
    logic mul;       // form the product, load the divider
    logic div_step;  // one restoring divide step
    logic fix;       // apply sign and offset, store the coordinate
    logic load;      // copy results into the output register
    logic sel;       // coordinate lane: 0 is x, 1 is y
  } rpwf_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
  } rpwf_status_t;

endpackage

FILE: hdl/rpwf_if.sv
// ---------------------------------------------------------------------------
// rpwf_if: channel interfaces for the RC pulse width mapper
// Input event channel, result channel and register write channel, each
// with valid/ready and a payload.
// ---------------------------------------------------------------------------
interface rpwf_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        channel;
  logic        pin_level;
  logic [15:0] timer_count;

  modport source(output valid, kind, channel, pin_level, timer_count, input ready);
  modport sink(input valid, kind, channel, pin_level, timer_count, output ready);
endinterface

interface rpwf_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] width_x;
  logic        [15:0] width_y;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic               failsafe_x;
  logic               failsafe_y;

  modport source(output valid, width_x, width_y, coord_x, coord_y, failsafe_x,
                 failsafe_y, input ready);
  modport sink(input valid, width_x, width_y, coord_x, coord_y, failsafe_x,
               failsafe_y, output ready);
endinterface

interface rpwf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/rpwf_ctrl.sv
// ---------------------------------------------------------------------------
// rpwf_ctrl: sequencer for the RC pulse width mapper
// Accepts one event, then walks both coordinate lanes through setup,
// multiply, a 16-step divide and fixup, then loads the output register.
// ---------------------------------------------------------------------------
module rpwf_ctrl
  import rpwf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rpwf_status_t status,
  output rpwf_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIX   = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state, state_next;
  logic              sel, sel_next;
  logic [STEP_W-1:0] step, step_next;

  always_comb begin
    state_next   = state;
    sel_next     = sel;
    step_next    = step;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.sel      = sel;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.apply  = 1'b1;
          sel_next   = 1'b0;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_LAST) state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix = 1'b1;
        if (sel) begin
          state_next = ST_LOAD;
        end else begin
          sel_next   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      step  <= step_next;
    end
  end

  a_accept_starts_x: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SETUP && !sel))
    else $error("accepted beat did not start the x lane");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step == STEP_LAST) |=> (state == ST_FIX))
    else $error("divide did not end after the last step");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (status.out_free && sel))
    else $error("result loaded into a busy output register or before the y lane");

endmodule

FILE: hdl/rpwf_datapath.sv
// ---------------------------------------------------------------------------
// rpwf_datapath: channel state, registers and coordinate mapping
// Holds the configuration, per-channel capture state and overflow counters,
// a shared multiply and restoring divider for the mapping, and the output
// register.
// ---------------------------------------------------------------------------
module rpwf_datapath
  import rpwf_pkg::*;
#(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rpwf_cmd_t            cmd,
  output rpwf_status_t         status,
  // register writes
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  // event payload
  input  logic                 kind,
  input  logic                 channel,
  input  logic                 pin_level,
  input  logic [DATA_W-1:0]    timer_count,
  // result
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_width_x,
  output logic [DATA_W-1:0]    out_width_y,
  output logic [DATA_W-1:0]    out_coord_x,
  output logic [DATA_W-1:0]    out_coord_y,
  output logic                 out_failsafe_x,
  output logic                 out_failsafe_y
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam bit          Y_OK = (NUM_CHANNELS > 1);
  localparam logic [CH_W-1:0] Y_IDX = CH_W'(Y_OK ? 1 : 0);

  // configuration
  logic [DATA_W-1:0] pulse_min, pulse_max, coord_min, coord_max, stopped_width;
  logic [CNT_W-1:0]  overflow_limit;

  // channel state
  logic [DATA_W-1:0] start_count      [NUM_CHANNELS];
  logic [DATA_W-1:0] pulse_width      [NUM_CHANNELS];
  logic [CNT_W-1:0]  missed_overflows [NUM_CHANNELS];
  logic [DATA_W-1:0] start_count_next [NUM_CHANNELS];
  logic [DATA_W-1:0] pulse_width_next [NUM_CHANNELS];
  logic [CNT_W-1:0]  missed_next      [NUM_CHANNELS];

  // mapping
  logic [DATA_W-1:0] diff, span_p, span_mag, quo;
  logic              span_neg, degen;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] res_x, res_y;

  logic [CH_W-1:0]   ch_idx, map_idx;
  logic              ch_ok, map_ok;
  logic [DATA_W-1:0] w_sel, x_clamp;
  logic [DATA_W:0]   span_c, trial;
  logic              ge;
  logic [DATA_W-1:0] q_signed, res;
  logic [2*DATA_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min      <= PULSE_MIN_RST;
      pulse_max      <= PULSE_MAX_RST;
      coord_min      <= COORD_MIN_RST;
      coord_max      <= COORD_MAX_RST;
      stopped_width  <= STOPPED_WIDTH_RST;
      overflow_limit <= OVF_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_MIN:     pulse_min      <= cfg_data;
        REG_PULSE_MAX:     pulse_max      <= cfg_data;
        REG_COORD_MIN:     coord_min      <= cfg_data;
        REG_COORD_MAX:     coord_max      <= cfg_data;
        REG_STOPPED_WIDTH: stopped_width  <= cfg_data;
        REG_OVF_LIMIT:     overflow_limit <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ch_idx = CH_W'(channel);
  assign ch_ok  = Y_OK || (channel == 1'b0);

  always_comb begin
    start_count_next = start_count;
    pulse_width_next = pulse_width;
    missed_next      = missed_overflows;
    if (cmd.apply) begin
      if (kind == KIND_TICK) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (missed_overflows[i] != {CNT_W{1'b1}}) begin
            missed_next[i] = missed_overflows[i] + 1'b1;
          end
          if (missed_next[i] > overflow_limit) pulse_width_next[i] = stopped_width;
        end
      end else if (ch_ok) begin
        if (pin_level == LEVEL_HIGH) begin
          start_count_next[ch_idx] = timer_count;
        end else begin
          pulse_width_next[ch_idx] = timer_count - start_count[ch_idx];
          missed_next[ch_idx]      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_count[i]      <= '0;
        pulse_width[i]      <= STOPPED_WIDTH_RST;
        missed_overflows[i] <= '0;
      end
    end else begin
      start_count      <= start_count_next;
      pulse_width      <= pulse_width_next;
      missed_overflows <= missed_next;
    end
  end

  // lane setup: clamp, then spans; negative slope handled as sign + magnitude
  assign map_idx = CH_W'(cmd.sel);
  assign map_ok  = Y_OK || !cmd.sel;
  assign w_sel   = map_ok ? pulse_width[map_idx] : '0;
  assign x_clamp = (w_sel < pulse_min) ? pulse_min :
                   (w_sel > pulse_max) ? pulse_max : w_sel;
  assign span_c  = {coord_max[DATA_W-1], coord_max} - {coord_min[DATA_W-1], coord_min};

  // |diff * slope| < 2^16 * span_p, so the quotient fits 16 bits
  assign prod  = diff * span_mag;
  assign trial = {rem, quo[DATA_W-1]};
  assign ge    = (trial >= {1'b0, span_p});

  assign q_signed = span_neg ? (~quo + 1'b1) : quo;
  assign res      = degen ? coord_min : (q_signed + coord_min);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      diff     <= x_clamp - pulse_min;
      span_p   <= pulse_max - pulse_min;
      degen    <= (pulse_max <= pulse_min);
      span_neg <= span_c[DATA_W];
      span_mag <= span_c[DATA_W] ? DATA_W'(~span_c + 1'b1) : span_c[DATA_W-1:0];
    end
    if (cmd.mul) begin
      rem <= prod[2*DATA_W-1:DATA_W];
      quo <= prod[DATA_W-1:0];
    end else if (cmd.div_step) begin
      rem <= ge ? DATA_W'(trial - {1'b0, span_p}) : trial[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], ge};
    end
    if (cmd.fix) begin
      if (cmd.sel) res_y <= res;
      else         res_x <= res;
    end
  end

  // output register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_width_x    <= pulse_width[0];
      out_coord_x    <= res_x;
      out_failsafe_x <= (missed_overflows[0] > overflow_limit);
      out_width_y    <= Y_OK ? pulse_width[Y_IDX] : '0;
      out_coord_y    <= Y_OK ? res_y : '0;
      out_failsafe_y <= Y_OK && (missed_overflows[Y_IDX] > overflow_limit);
    end
  end

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && !degen) |-> (rem < span_p))
    else $error("divider remainder not below divisor");

  a_fall_clears_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && kind == KIND_EDGE && channel == 1'b0 && pin_level != LEVEL_HIGH)
    |=> (missed_overflows[0] == '0))
    else $error("falling edge did not clear the overflow count");

endmodule

FILE: hdl/rc_pulse_width_failsafe_mapper.sv
// ---------------------------------------------------------------------------
// rc_pulse_width_failsafe_mapper: two-channel RC pulse capture with failsafe
// Measures pulse widths from timestamped pin edges, times out channels on
// missed timer overflows, and maps clamped widths to signed coordinates.
//
//   channel     role    payload
//   item_in     sink    kind, channel, pin_level, timer_count
//   result_out  source  width_x/y, coord_x/y, failsafe_x/y
//   cfg         sink    index (register), data
//
// Each event runs from accept to result valid through two lanes of setup,
// multiply, 16-step restoring divide and fixup that share one divider.
// A new event is taken once the previous result is in the output register,
// so a stalled result holds off the next accept only if it is still there
// when the next one finishes. cfg is always ready. rst is synchronous and
// loads the register defaults and the stopped width into both channels.
// ---------------------------------------------------------------------------
module rc_pulse_width_failsafe_mapper
  import rpwf_pkg::*;
#(
  parameter int NUM_CHANNELS = 2
) (
  input  logic       clk,
  input  logic       rst,
  rpwf_in_if.sink    item_in,
  rpwf_out_if.source result_out,
  rpwf_cfg_if.sink   cfg
);

  rpwf_cmd_t    cmd;
  rpwf_status_t status;
  logic         in_ready;
  logic [DATA_W-1:0] coord_x, coord_y;

  assign item_in.ready = in_ready;
  assign cfg.ready     = 1'b1;

  rpwf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rpwf_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .kind           (item_in.kind),
    .channel        (item_in.channel),
    .pin_level      (item_in.pin_level),
    .timer_count    (item_in.timer_count),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .out_width_x    (result_out.width_x),
    .out_width_y    (result_out.width_y),
    .out_coord_x    (coord_x),
    .out_coord_y    (coord_y),
    .out_failsafe_x (result_out.failsafe_x),
    .out_failsafe_y (result_out.failsafe_y)
  );

  assign result_out.coord_x = signed'(coord_x);
  assign result_out.coord_y = signed'(coord_y);

endmodule

FILE: tb/sv/rc_pulse_width_failsafe_mapper_tb.sv
// ---------------------------------------------------------------------------
// rc_pulse_width_failsafe_mapper_tb: self-checking bench for the RC mapper
// Feeds pin edges and overflow ticks through the event channel and keeps its
// own capture/failsafe/mapping state. Each result beat is checked against the
// oldest predicted report. Register settings change between drained phases.
// ---------------------------------------------------------------------------
module rc_pulse_width_failsafe_mapper_tb;
  import rpwf_pkg::*;

  localparam int NUM_CH = 2;
  localparam logic CH_X = 1'b0;
  localparam logic CH_Y = 1'b1;
  localparam logic LEVEL_LOW = ~LEVEL_HIGH;
  localparam logic [CNT_W-1:0] MISS_SAT = 8'hFF;
  localparam logic [REG_IDX_W-1:0] REG_NONE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_NONE_B = 3'd7;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic        kind;
    logic        channel;
    logic        pin_level;
    logic [15:0] timer_count;
  } pin_evt_t;

  typedef struct {
    logic        [15:0] width_x;
    logic        [15:0] width_y;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic               fs_x;
    logic               fs_y;
  } ch_report_t;

  logic clk;
  logic rst;

  rpwf_in_if  in_if ();
  rpwf_out_if out_if ();
  rpwf_cfg_if cfg_if ();

  rc_pulse_width_failsafe_mapper #(.NUM_CHANNELS(NUM_CH)) dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (in_if),
    .result_out (out_if),
    .cfg        (cfg_if)
  );

  // register mirror
  logic        [15:0] p_min, p_max, stop_w;
  logic signed [15:0] c_min, c_max;
  logic        [7:0]  ovf_lim;

  // channel state mirror
  logic [15:0] start_cnt [NUM_CH];
  logic [15:0] width_cnt [NUM_CH];
  logic [7:0]  miss_cnt  [NUM_CH];

  pin_evt_t   pend_events [$];
  ch_report_t due_reports [$];
  pin_evt_t   tx_item;

  int unsigned n_queued, n_taken, n_bad;
  bit in_fire, out_fire;
  bit hold_req, hold_rx;
  bit tx_quiet, rx_quiet;
  int unsigned tx_wait, tx_left, rx_wait, rx_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1500000;
    $display("FAIL rc_pulse_width_failsafe_mapper");
    $finish;
  end

  function automatic logic [15:0] map_coord(logic [15:0] w);
    longint lo, hi, x, cmin, cmax, r;
    lo = p_min;
    hi = p_max;
    x = w;
    cmin = c_min;
    cmax = c_max;
    if (x < lo) x = lo;
    else if (x > hi) x = hi;
    if (hi <= lo) r = cmin;
    else r = (x - lo) * (cmax - cmin) / (hi - lo) + cmin;
    return r[15:0];
  endfunction

  function automatic void write_mirror(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      REG_PULSE_MIN:     p_min = val;
      REG_PULSE_MAX:     p_max = val;
      REG_COORD_MIN:     c_min = val;
      REG_COORD_MAX:     c_max = val;
      REG_STOPPED_WIDTH: stop_w = val;
      REG_OVF_LIMIT:     ovf_lim = val[7:0];
      default: ;
    endcase
  endfunction

  // advance capture state by one event and form the report it produces
  function automatic ch_report_t capture_step(pin_evt_t ev);
    ch_report_t rep;
    int i;
    if (ev.kind == KIND_TICK) begin
      for (i = 0; i < NUM_CH; i++) begin
        if (miss_cnt[i] < MISS_SAT) miss_cnt[i]++;
        if (miss_cnt[i] > ovf_lim) width_cnt[i] = stop_w;
      end
    end else if (ev.pin_level == LEVEL_HIGH) begin
      start_cnt[ev.channel] = ev.timer_count;
    end else begin
      width_cnt[ev.channel] = ev.timer_count - start_cnt[ev.channel];
      miss_cnt[ev.channel] = '0;
    end
    rep.width_x = width_cnt[CH_X];
    rep.width_y = width_cnt[CH_Y];
    rep.coord_x = map_coord(width_cnt[CH_X]);
    rep.coord_y = map_coord(width_cnt[CH_Y]);
    rep.fs_x = miss_cnt[CH_X] > ovf_lim;
    rep.fs_y = miss_cnt[CH_Y] > ovf_lim;
    return rep;
  endfunction

  // prediction and checking, all sampled at the rising edge
  always @(posedge clk) begin
    pin_evt_t ev;
    ch_report_t want, got;
    in_fire = in_if.valid && in_if.ready;
    out_fire = out_if.valid && out_if.ready;
    if (rst) begin
      p_min = PULSE_MIN_RST;
      p_max = PULSE_MAX_RST;
      c_min = COORD_MIN_RST;
      c_max = COORD_MAX_RST;
      stop_w = STOPPED_WIDTH_RST;
      ovf_lim = OVF_LIMIT_RST;
      for (int i = 0; i < NUM_CH; i++) begin
        start_cnt[i] = '0;
        width_cnt[i] = STOPPED_WIDTH_RST;
        miss_cnt[i] = '0;
      end
    end else begin
      if (cfg_if.valid && cfg_if.ready) write_mirror(cfg_if.index, cfg_if.data);
      if (in_fire) begin
        ev.kind = in_if.kind;
        ev.channel = in_if.channel;
        ev.pin_level = in_if.pin_level;
        ev.timer_count = in_if.timer_count;
        due_reports.push_back(capture_step(ev));
        n_taken++;
      end
      if (out_fire) begin
        got.width_x = out_if.width_x;
        got.width_y = out_if.width_y;
        got.coord_x = out_if.coord_x;
        got.coord_y = out_if.coord_y;
        got.fs_x = out_if.failsafe_x;
        got.fs_y = out_if.failsafe_y;
        if (due_reports.size() == 0) begin
          if (n_bad < 10) $display("unexpected result beat: w=%h/%h c=%0d/%0d f=%b/%b",
                                   got.width_x, got.width_y, got.coord_x, got.coord_y,
                                   got.fs_x, got.fs_y);
          n_bad++;
        end else begin
          want = due_reports.pop_front();
          if (got.width_x !== want.width_x || got.width_y !== want.width_y ||
              got.coord_x !== want.coord_x || got.coord_y !== want.coord_y ||
              got.fs_x !== want.fs_x || got.fs_y !== want.fs_y) begin
            if (n_bad < 10) begin
              $display("mismatch: exp w=%h/%h c=%0d/%0d f=%b/%b", want.width_x,
                       want.width_y, want.coord_x, want.coord_y, want.fs_x, want.fs_y);
              $display("          got w=%h/%h c=%0d/%0d f=%b/%b", got.width_x,
                       got.width_y, got.coord_x, got.coord_y, got.fs_x, got.fs_y);
            end
            n_bad++;
          end
        end
      end
    end
  end

  // event driver: one beat per queued event, random gap after each
  always @(negedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (in_fire) begin
        if (tx_left == 0) begin
          tx_quiet = ($urandom_range(0, 2) == 0);
          tx_left = $urandom_range(10, 60);
        end
        tx_left--;
        tx_wait = tx_quiet ? 0 : $urandom_range(0, 19);
      end
      if (tx_wait > 0) begin
        tx_wait--;
        in_if.valid <= 1'b0;
      end else if (pend_events.size() > 0) begin
        tx_item = pend_events.pop_front();
        in_if.kind <= tx_item.kind;
        in_if.channel <= tx_item.channel;
        in_if.pin_level <= tx_item.pin_level;
        in_if.timer_count <= tx_item.timer_count;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stall after each beat, plus the long hold-off
  always @(negedge clk) begin
    if (out_fire) begin
      if (rx_left == 0) begin
        rx_quiet = ($urandom_range(0, 2) == 0);
        rx_left = $urandom_range(10, 60);
      end
      rx_left--;
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_if.ready <= !rst && !hold_rx && rx_wait == 0;
  end

  always begin
    wait (hold_req);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
    hold_req = 1'b0;
  end

  task automatic push_evt(input logic k, input logic ch, input logic lvl,
                          input logic [15:0] cnt);
    pin_evt_t ev;
    ev.kind = k;
    ev.channel = ch;
    ev.pin_level = lvl;
    ev.timer_count = cnt;
    pend_events.push_back(ev);
    n_queued++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.data <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] pmin, input logic [15:0] pmax,
                            input logic [15:0] cmin, input logic [15:0] cmax,
                            input logic [15:0] stop, input logic [7:0] lim);
    write_reg(REG_PULSE_MIN, pmin);
    write_reg(REG_PULSE_MAX, pmax);
    write_reg(REG_COORD_MIN, cmin);
    write_reg(REG_COORD_MAX, cmax);
    write_reg(REG_STOPPED_WIDTH, stop);
    write_reg(REG_OVF_LIMIT, {8'h00, lim});
  endtask

  // wait until every event is taken and every report checked; ends on a rising edge
  task automatic wait_idle();
    do @(negedge clk); while (n_taken != n_queued || due_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed pulses, some ticks, a little edge noise
  task automatic gen_mix(input int n, input int unsigned w_lo, input int unsigned w_hi,
                         input int tick_pct, input bit pauses);
    int made, since;
    int unsigned r, wa, wb;
    logic [15:0] ta, tb;
    logic ch;
    made = 0;
    since = 0;
    @(posedge clk);
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_evt(KIND_EDGE, 1'($urandom), 1'($urandom), 16'($urandom));
        made++;
        since++;
      end else if (r < 8 + tick_pct) begin
        push_evt(KIND_TICK, 1'($urandom), 1'($urandom), 16'($urandom));
        made++;
        since++;
      end else if (r < 8 + tick_pct + 15) begin
        // both channels overlapping
        ta = 16'($urandom);
        tb = 16'($urandom);
        wa = $urandom_range(w_lo, w_hi);
        wb = $urandom_range(w_lo, w_hi);
        push_evt(KIND_EDGE, CH_X, LEVEL_HIGH, ta);
        push_evt(KIND_EDGE, CH_Y, LEVEL_HIGH, tb);
        push_evt(KIND_EDGE, CH_Y, LEVEL_LOW, 16'(tb + wb));
        push_evt(KIND_EDGE, CH_X, LEVEL_LOW, 16'(ta + wa));
        made += 4;
        since += 4;
      end else begin
        ch = 1'($urandom);
        ta = 16'($urandom);
        wa = $urandom_range(w_lo, w_hi);
        push_evt(KIND_EDGE, ch, LEVEL_HIGH, ta);
        push_evt(KIND_EDGE, ch, LEVEL_LOW, 16'(ta + wa));
        made += 2;
        since += 2;
      end
      if (pauses && since >= 40) begin
        since = 0;
        if ($urandom_range(0, 2) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    logic [15:0] lo, hi;
    int unsigned w_lo, w_hi;
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.kind = KIND_EDGE;
    in_if.channel = CH_X;
    in_if.pin_level = LEVEL_LOW;
    in_if.timer_count = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_PULSE_MIN;
    cfg_if.data = '0;
    n_queued = 0;
    n_taken = 0;
    n_bad = 0;
    hold_req = 1'b0;
    hold_rx = 1'b0;
    tx_wait = 0;
    tx_left = 0;
    rx_wait = 0;
    rx_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset register values
    @(posedge clk);
    push_evt(KIND_TICK, CH_Y, LEVEL_HIGH, 16'hFFFF);       // tick fields ignored
    push_evt(KIND_EDGE, CH_X, LEVEL_LOW, 16'd1234);        // fall with no rise
    push_evt(KIND_EDGE, CH_X, LEVEL_HIGH, 16'hFFFF);
    push_evt(KIND_EDGE, CH_X, LEVEL_LOW, 16'h0000);        // wraps to 1, below floor
    push_evt(KIND_EDGE, CH_Y, LEVEL_HIGH, 16'h0000);
    push_evt(KIND_EDGE, CH_Y, LEVEL_LOW, 16'hFFFF);        // widest, above ceiling
    push_evt(KIND_EDGE, CH_X, LEVEL_HIGH, 16'd100);
    push_evt(KIND_EDGE, CH_X, LEVEL_LOW, 16'd1100);        // exactly at floor
    push_evt(KIND_EDGE, CH_Y, LEVEL_HIGH, 16'd5000);
    push_evt(KIND_EDGE, CH_Y, LEVEL_LOW, 16'd7000);        // exactly at ceiling
    push_evt(KIND_EDGE, CH_X, LEVEL_HIGH, 16'd0);
    push_evt(KIND_EDGE, CH_X, LEVEL_LOW, 16'd1500);        // midpoint
    push_evt(KIND_EDGE, CH_X, LEVEL_HIGH, 16'd10);
    push_evt(KIND_EDGE, CH_X, LEVEL_LOW, 16'd10);          // zero width
    push_evt(KIND_EDGE, CH_Y, LEVEL_HIGH, 16'd3);
    push_evt(KIND_EDGE, CH_Y, LEVEL_LOW, 16'd1502);        // fractional quotient
    repeat (5) push_evt(KIND_TICK, CH_X, LEVEL_LOW, 16'h0000);  // into failsafe
    push_evt(KIND_EDGE, CH_X, LEVEL_HIGH, 16'd200);
    push_evt(KIND_EDGE, CH_X, LEVEL_LOW, 16'd1900);        // x recovers, y stays out
    push_evt(KIND_TICK, CH_Y, LEVEL_LOW, 16'h5A5A);
    wait_idle();

    // full range, widest coordinate span, timeout on first tick
    set_config(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 8'd0);
    gen_mix(200, 0, 65535, 20, 1'b1);
    wait_idle();

    // falling slope: negative quotients truncate toward zero
    set_config(16'd500, 16'd2500, 16'h7FFF, 16'h8000, 16'hFFFF, 8'd1);
    gen_mix(200, 300, 2700, 25, 1'b1);
    wait_idle();

    // ceiling equal to floor; unused register indexes
    set_config(16'd1500, 16'd1500, 16'hFF38, 16'd200, 16'd1500, 8'd2);
    write_reg(REG_NONE_A, 16'($urandom));
    write_reg(REG_NONE_B, 16'($urandom));
    gen_mix(100, 1000, 2000, 20, 1'b1);
    wait_idle();

    // ceiling below floor
    set_config(16'd2000, 16'd1000, 16'd7, 16'hFFF0, 16'd1200, 8'd4);
    gen_mix(100, 500, 2500, 20, 1'b1);
    wait_idle();

    for (int k = 0; k < 3; k++) begin
      lo = 16'($urandom_range(0, 60000));
      hi = 16'($urandom_range(int'(lo) + 1, 65535));
      set_config(lo, hi, 16'($urandom), 16'($urandom), 16'($urandom),
                 8'($urandom_range(0, 10)));
      w_lo = (lo > 200) ? lo - 200 : 0;
      w_hi = (int'(hi) + 200 > 65535) ? 65535 : hi + 200;
      if (k == 0) begin
        // receiver stalls long while events keep coming
        @(posedge clk);
        hold_req = 1'b1;
        gen_mix(80, w_lo, w_hi, 20, 1'b0);
        wait_idle();
      end
      gen_mix(270, w_lo, w_hi, 20, 1'b1);
      wait_idle();
    end

    // counter saturation at the top limit; new stopped width only on timeout
    write_reg(REG_OVF_LIMIT, 16'd254);
    write_reg(REG_STOPPED_WIDTH, 16'h0ABC);
    @(posedge clk);
    for (int i = 0; i < 320; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        push_evt(KIND_EDGE, CH_Y, LEVEL_HIGH, 16'd1000);
        push_evt(KIND_EDGE, CH_Y, LEVEL_LOW, 16'($urandom_range(1900, 3100)));
      end else begin
        push_evt(KIND_TICK, 1'($urandom), 1'($urandom), 16'($urandom));
      end
    end
    wait_idle();
    repeat (60) @(posedge clk);

    if (n_bad == 0 && due_reports.size() == 0) begin
      $display("PASS rc_pulse_width_failsafe_mapper");
    end else begin
      $display("FAIL rc_pulse_width_failsafe_mapper");
    end
    $finish;
  end

endmodule
